// ===== hdl/ssp_pkg.sv =====
// Shared types, constants and tables of the spiral sphere point generator.
package ssp_pkg;

  localparam int COUNT_W    = 16;
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 15;
  localparam int PHASE_W    = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 2;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 16'd256;
  localparam logic [COUNT_W-1:0] POINT_COUNT_MIN   = 16'd2;

  // serial divider
  localparam int DIV_REM_W = 42;
  localparam int DIV_DVD_W = 40;
  localparam int DIV_Q_W   = 25;
  localparam int DIV_CNT_W = 6;

  // serial square root
  localparam int SQ_RAD_W  = 48;
  localparam int SQ_ROOT_W = 24;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_CNT_W  = 5;

  localparam logic [31:0] STEP_Q32    = 32'd2460834992;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

  localparam logic signed [17:0] H_OFFSET  = 18'sd32768;
  localparam logic signed [17:0] H_MAX     = 18'sd32767;
  localparam logic [16:0]        COORD_ONE = 17'd32768;

  typedef struct packed {
    logic [COUNT_W-1:0] index;
    logic               last;
    logic               pole;
  } point_desc_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [COUNT_W-1:0] point_index;
    logic               last_point;
  } point_res_t;

  // floor(2^32 / d) for the Horner divisors 72, 42, 20, 6
  function automatic logic [31:0] horner_recip(input logic [1:0] k);
    logic [31:0] m;
    unique case (k)
      2'd0: m = 32'd59652323;
      2'd1: m = 32'd102261126;
      2'd2: m = 32'd214748364;
      2'd3: m = 32'd715827882;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] horner_div(input logic [1:0] k);
    logic [6:0] d;
    unique case (k)
      2'd0: d = 7'd72;
      2'd1: d = 7'd42;
      2'd2: d = 7'd20;
      2'd3: d = 7'd6;
      default: d = 7'd1;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/ssp_fifo.sv =====
// Small register queue between the front, the back and the result port.
module ssp_fifo import ssp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/ssp_front.sv =====
// Front end: point counter and classification of each accepted item.
module ssp_front import ssp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               restart,
  input  logic [COUNT_W-1:0] n,
  output point_desc_t        desc
);

  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] last_idx, idx;

  assign last_idx   = n - 1'b1;
  assign idx        = (restart || cnt_r >= n) ? '0 : cnt_r;
  assign desc.index = idx;
  assign desc.last  = (idx == last_idx);
  assign desc.pole  = (idx == '0) || (idx == last_idx);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = desc.last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/ssp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ssp_div import ssp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_REM_W-1:0] rem_init,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_REM_W-1:0] divisor,
  input  logic [DIV_CNT_W-1:0] count,
  output logic                 busy,
  output logic [DIV_Q_W-1:0]   quotient
);

  logic [DIV_REM_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_Q_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIV_REM_W:0]   rem_sh, diff;
  logic                 ge;

  assign rem_sh   = {rem_r, dvd_r[DIV_DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, den_r});
  assign diff     = rem_sh - {1'b0, den_r};
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = rem_init;
      den_nxt  = divisor;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      cnt_nxt  = count;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      dvd_nxt  = {dvd_r[DIV_DVD_W-2:0], 1'b0};
      quo_nxt  = {quo_r[DIV_Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// ===== hdl/ssp_sqrt.sv =====
// Integer square root, one root bit per cycle.
module ssp_sqrt import ssp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_RAD_W-1:0]  radicand,
  input  logic [SQ_CNT_W-1:0]  count,
  output logic                 busy,
  output logic [SQ_ROOT_W-1:0] root
);

  logic [SQ_RAD_W-1:0]  rad_r, rad_nxt;
  logic [SQ_REM_W-1:0]  rem_r, rem_nxt;
  logic [SQ_ROOT_W-1:0] root_r, root_nxt;
  logic [SQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [SQ_REM_W+1:0]  rem_sh, trial, diff;
  logic                 ge;

  assign rem_sh = {rem_r, rad_r[SQ_RAD_W-1:SQ_RAD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;
  assign busy   = busy_r;
  assign root   = root_r;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = count;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[SQ_RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
      root_nxt = {root_r[SQ_ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != SQ_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

endmodule

// ===== hdl/ssp_back.sv =====
// Back end: height, azimuth step, sine/cosine and scaling for one point at a time.
module ssp_back import ssp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] n,
  input  logic               cmd_empty,
  input  point_desc_t        cmd_data,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output point_res_t         res_data
);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_HDIV  = 19'h00002,
    ST_HSQ   = 19'h00004,
    ST_SGO   = 19'h00008,
    ST_SWAIT = 19'h00010,
    ST_DEN   = 19'h00020,
    ST_DGO   = 19'h00040,
    ST_DWAIT = 19'h00080,
    ST_TX    = 19'h00100,
    ST_TX2   = 19'h00200,
    ST_TRM   = 19'h00400,
    ST_TRC   = 19'h00800,
    ST_TXT   = 19'h01000,
    ST_TV    = 19'h02000,
    ST_TVS   = 19'h04000,
    ST_SCX   = 19'h08000,
    ST_SCY   = 19'h10000,
    ST_SCD   = 19'h20000,
    ST_PUSH  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  point_desc_t          desc_r, desc_nxt;
  logic signed [17:0]   hq_r, hq_nxt;
  logic [SQ_ROOT_W-1:0] rq_r, rq_nxt;
  logic [15:0]          sq_r, sq_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [31:0]          x_r, x_nxt, x2_r, x2_nxt, t_r, t_nxt, a_r, a_nxt;
  logic [30:0]          sv_r, sv_nxt, cv_r, cv_nxt;
  logic [1:0]           k_r, k_nxt;
  logic                 which_r, which_nxt;
  logic [COORD_W-1:0]   outx_r, outx_nxt, outy_r, outy_nxt;
  logic [63:0]          prod_r, prod_nxt;
  logic [31:0]          mul_a, mul_b;

  logic                 div_start, div_busy;
  logic [DIV_REM_W-1:0] div_rem0, div_den;
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_Q_W-1:0]   div_q;
  logic                 sq_start, sq_busy;
  logic [SQ_RAD_W-1:0]  sq_rad;
  logic [SQ_CNT_W-1:0]  sq_cnt;
  logic [SQ_ROOT_W-1:0] sq_root;

  logic [COUNT_W-1:0]   last_idx;
  logic [32:0]          h_num;
  logic [15:0]          habs;
  logic [17:0]          hneg;
  logic [DIV_Q_W-1:0]   q_plus1;
  logic [29:0]          r30;
  logic [31:0]          qe, qfix;
  logic [6:0]           dk;
  logic [38:0]          qd, rem_k;
  logic [31:0]          vraw;
  logic [30:0]          vcl;
  logic [1:0]           quad;
  logic [30:0]          magc, mags;
  logic                 negc, negs;
  logic [COORD_W-1:0]   zsat;

  function automatic logic [COORD_W-1:0] scale_coord(input logic [63:0] p, input logic neg);
    logic [63:0] rnd;
    logic [16:0] m;
    logic [16:0] mc;
    logic [16:0] v;
    rnd = p + 64'h2000_0000;
    m   = rnd[46:30];
    if (neg) begin
      mc = (m > COORD_ONE) ? COORD_ONE : m;
      v  = 17'd0 - mc;
    end else begin
      v  = (m > COORD_ONE - 1'b1) ? COORD_ONE - 1'b1 : m;
    end
    return v[COORD_W-1:0];
  endfunction

  ssp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem0),
    .dividend (div_dvd),
    .divisor  (div_den),
    .count    (div_cnt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  ssp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .count    (sq_cnt),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign last_idx = n - 1'b1;
  assign h_num    = {cmd_data.index, 17'b0} + {17'b0, last_idx};
  assign hneg     = 18'd0 - hq_r;
  assign habs     = hq_r[17] ? hneg[15:0] : hq_r[15:0];
  assign q_plus1  = div_q + 1'b1;
  assign r30      = {phase_r[PHASE_W-3:0], 8'b0};

  // Horner divide by a small constant: reciprocal estimate plus one correction
  assign qe    = prod_r[63:32];
  assign dk    = horner_div(k_r);
  assign qd    = qe * dk;
  assign rem_k = {7'b0, a_r} - qd;
  assign qfix  = (rem_k >= {32'b0, dk}) ? qe + 1'b1 : qe;

  assign vraw = prod_r[61:30];
  assign vcl  = (vraw > ONE_Q30) ? ONE_Q30[30:0] : vraw[30:0];

  assign quad = phase_r[PHASE_W-1:PHASE_W-2];
  always_comb begin
    unique case (quad)
      2'd0: begin magc = cv_r; negc = 1'b0; mags = sv_r; negs = 1'b0; end
      2'd1: begin magc = sv_r; negc = 1'b1; mags = cv_r; negs = 1'b0; end
      2'd2: begin magc = cv_r; negc = 1'b1; mags = sv_r; negs = 1'b1; end
      2'd3: begin magc = sv_r; negc = 1'b0; mags = cv_r; negs = 1'b1; end
      default: begin magc = cv_r; negc = 1'b0; mags = sv_r; negs = 1'b0; end
    endcase
  end

  assign zsat = (hq_r > H_MAX) ? H_MAX[COORD_W-1:0] : hq_r[COORD_W-1:0];

  assign res_data.pos_x       = outx_r;
  assign res_data.pos_y       = outy_r;
  assign res_data.pos_z       = zsat;
  assign res_data.point_index = desc_r.index;
  assign res_data.last_point  = desc_r.last;

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    hq_nxt    = hq_r;
    rq_nxt    = rq_r;
    sq_nxt    = sq_r;
    phase_nxt = phase_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    t_nxt     = t_r;
    a_nxt     = a_r;
    sv_nxt    = sv_r;
    cv_nxt    = cv_r;
    k_nxt     = k_r;
    which_nxt = which_r;
    outx_nxt  = outx_r;
    outy_nxt  = outy_r;
    mul_a     = '0;
    mul_b     = '0;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    div_start = 1'b0;
    div_rem0  = '0;
    div_dvd   = {h_num, 7'b0};
    div_den   = {25'b0, last_idx, 1'b0};
    div_cnt   = DIV_CNT_W'(33);
    sq_start  = 1'b0;
    sq_rad    = {n, 32'b0};
    sq_cnt    = SQ_CNT_W'(24);

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          desc_nxt  = cmd_data;
          div_start = 1'b1;
          sq_start  = 1'b1;
          k_nxt     = 2'd0;
          which_nxt = 1'b0;
          state_nxt = ST_HDIV;
        end
      end
      ST_HDIV: begin
        if (!div_busy && !sq_busy) begin
          hq_nxt    = $signed({1'b0, div_q[16:0]}) - H_OFFSET;
          rq_nxt    = sq_root;
          state_nxt = ST_HSQ;
        end
      end
      ST_HSQ: begin
        mul_a     = {16'b0, habs};
        mul_b     = {16'b0, habs};
        state_nxt = ST_SGO;
      end
      ST_SGO: begin
        sq_start  = 1'b1;
        sq_rad    = {ONE_Q30 - prod_r[31:0], 16'b0};
        sq_cnt    = SQ_CNT_W'(16);
        state_nxt = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (!sq_busy) begin
          sq_nxt = sq_root[15:0];
          if (desc_r.pole) begin
            phase_nxt = '0;
            state_nxt = ST_TX;
          end else begin
            state_nxt = ST_DEN;
          end
        end
      end
      ST_DEN: begin
        mul_a     = {8'b0, rq_r};
        mul_b     = {16'b0, (sq_r == '0) ? 16'd1 : sq_r};
        state_nxt = ST_DGO;
      end
      ST_DGO: begin
        div_start = 1'b1;
        div_rem0  = {26'b0, STEP_Q32[31:16]};
        div_dvd   = {STEP_Q32[15:0], 24'b0};
        div_den   = prod_r[DIV_REM_W-1:0];
        div_cnt   = DIV_CNT_W'(40);
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!div_busy) begin
          phase_nxt = phase_r + q_plus1[PHASE_W:1];
          state_nxt = ST_TX;
        end
      end
      ST_TX: begin
        mul_a     = which_r ? ONE_Q30 - {2'b0, r30} : {2'b0, r30};
        mul_b     = HALF_PI_Q30;
        state_nxt = ST_TX2;
      end
      ST_TX2: begin
        x_nxt     = prod_r[61:30];
        mul_a     = prod_r[61:30];
        mul_b     = prod_r[61:30];
        state_nxt = ST_TRM;
      end
      ST_TRM: begin
        a_nxt = prod_r[61:30];
        if (k_r == 2'd0) begin
          x2_nxt = prod_r[61:30];
        end
        mul_a     = prod_r[61:30];
        mul_b     = horner_recip(k_r);
        state_nxt = ST_TRC;
      end
      ST_TRC: begin
        t_nxt = ONE_Q30 - qfix;
        if (k_r == 2'd3) begin
          state_nxt = ST_TV;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_TXT;
        end
      end
      ST_TXT: begin
        mul_a     = x2_r;
        mul_b     = t_r;
        state_nxt = ST_TRM;
      end
      ST_TV: begin
        mul_a     = x_r;
        mul_b     = t_r;
        state_nxt = ST_TVS;
      end
      ST_TVS: begin
        if (!which_r) begin
          sv_nxt    = vcl;
          which_nxt = 1'b1;
          k_nxt     = 2'd0;
          state_nxt = ST_TX;
        end else begin
          cv_nxt    = vcl;
          state_nxt = ST_SCX;
        end
      end
      ST_SCX: begin
        mul_a     = {16'b0, sq_r};
        mul_b     = {1'b0, magc};
        state_nxt = ST_SCY;
      end
      ST_SCY: begin
        outx_nxt  = scale_coord(prod_r, negc && (magc != '0));
        mul_a     = {16'b0, sq_r};
        mul_b     = {1'b0, mags};
        state_nxt = ST_SCD;
      end
      ST_SCD: begin
        outy_nxt  = scale_coord(prod_r, negs && (mags != '0));
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      k_r     <= 2'd0;
      which_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      which_r <= which_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    hq_r   <= hq_nxt;
    rq_r   <= rq_nxt;
    sq_r   <= sq_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    a_r    <= a_nxt;
    sv_r   <= sv_nxt;
    cv_r   <= cv_nxt;
    outx_r <= outx_nxt;
    outy_r <= outy_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// ===== hdl/spiral_sphere_point_generator_unit.sv =====
// Top level of the spiral sphere point generator: config register, front, queues, back.
// The back end takes one item at a time: the height divide, the square roots, the azimuth
//   step divide (interior points only) and the shared-multiplier sine/cosine sequence set
//   how soon it can take the next item.
// Reset: point_count returns to 256, counter and phase to zero, both queues empty.
module spiral_sphere_point_generator_unit import ssp_pkg::*; #(
  parameter int CMD_DEPTH = FIFO_DEPTH,
  parameter int RES_DEPTH = FIFO_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_restart,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z,
  output logic [COUNT_W-1:0]       out_point_index,
  output logic                     out_last_point,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  logic [COUNT_W-1:0] pc_r, pc_nxt, n_eff;
  logic               cfg_wr, in_acc;
  logic               cmd_full, cmd_empty, cmd_pop;
  logic               res_full, res_push;
  point_desc_t        front_desc, cmd_data;
  point_res_t         res_in, res_out;

  assign pready = 1'b1;
  assign prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, pc_r};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == '0);
  assign pc_nxt = cfg_wr ? pwdata[COUNT_W-1:0] : pc_r;
  assign n_eff  = (pc_r < POINT_COUNT_MIN) ? POINT_COUNT_MIN : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= POINT_COUNT_RESET;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign full   = cmd_full;
  assign in_acc = push && !cmd_full;

  ssp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .restart (in_restart),
    .n       (n_eff),
    .desc    (front_desc)
  );

  ssp_fifo #(
    .WIDTH ($bits(point_desc_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (front_desc),
    .rd_en   (cmd_pop),
    .rd_data (cmd_data),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  ssp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n_eff),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  ssp_fifo #(
    .WIDTH ($bits(point_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_pos_x       = $signed(res_out.pos_x);
  assign out_pos_y       = $signed(res_out.pos_y);
  assign out_pos_z       = $signed(res_out.pos_z);
  assign out_point_index = res_out.point_index;
  assign out_last_point  = res_out.last_point;

endmodule

// ===== hdl/ssp_checker.sv =====
// Port-level assertions of the spiral sphere point generator and their bind.
module ssp_checker import ssp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      empty,
  input logic                      pop,
  input logic signed [COORD_W-1:0] out_pos_x,
  input logic signed [COORD_W-1:0] out_pos_y,
  input logic signed [COORD_W-1:0] out_pos_z,
  input logic [COUNT_W-1:0]        out_point_index,
  input logic                      out_last_point
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_top_pole: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_point) |->
      (out_pos_z == 16'sh7FFF && out_pos_x == 16'sh0000 && out_pos_y == 16'sh0000 &&
       out_point_index != '0))
    else $error("last item is not the top pole");

  a_bottom_pole: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_point_index == '0) |->
      (out_pos_z == 16'sh8000 && out_pos_x == 16'sh0000 && out_pos_y == 16'sh0000))
    else $error("first item is not the bottom pole");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_point_index) && $stable(out_pos_z)))
    else $error("waiting item changed before pop");

endmodule

bind spiral_sphere_point_generator_unit ssp_checker u_ssp_checker (.*);

// ===== dv/spiral_sphere_point_generator_unit_test.sv =====
// Self-checking testbench of the spiral sphere point generator with its own point predictor.
`timescale 1ns / 100ps

module spiral_sphere_point_generator_unit_test;
  import ssp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT = '0;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_restart = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [COORD_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [COUNT_W-1:0] out_point_index;
  logic out_last_point;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  spiral_sphere_point_generator_unit DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [COUNT_W-1:0] model_count = POINT_COUNT_RESET;
  logic [PHASE_W-1:0] model_phase = '0;
  logic [COUNT_W-1:0] model_next = '0;
  point_res_t expected_points[$];

  int mismatches = 0;
  int items_in = 0, points_out = 0, restarts_sent = 0, last_seen = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] scaled_quotient(input logic [63:0] num, input int sh,
                                                  input logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    for (int k = 0; k < sh; k++) begin
      if (q >= (64'h1 << 61)) return 64'h1 << 62;
      q <<= 1;
      r <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 64'h1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x, x2, t, v;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    v = (x * t) >> 30;
    return (v > ONE_Q30) ? 64'(ONE_Q30) : v;
  endfunction

  function automatic logic [15:0] to_coord(input logic [63:0] s_q, input longint trig);
    logic [63:0] mag, m;
    mag = (trig < 0) ? 64'(-trig) : 64'(trig);
    m = (s_q * mag + (64'h1 << 29)) >> 30;
    if (trig < 0) begin
      if (m > 64'd32768) m = 64'd32768;
      return 16'(-longint'(m));
    end
    if (m > 64'd32767) m = 64'd32767;
    return m[15:0];
  endfunction

  function automatic point_res_t next_point(input logic rs);
    logic [63:0] n, last, i, one, hn, s_q, root_n, den, q, u, r;
    longint h_q, cv, sv, sq, cq;
    point_res_t p;
    n = (model_count < 2) ? 64'd2 : 64'(model_count);
    last = n - 1;
    i = 64'(model_next);
    one = 64'h1 << COORD_FRAC;
    if (rs || i >= n) i = 0;
    hn = ((one << 2) * i + last) / (last << 1);
    h_q = longint'(hn) - longint'(one);
    s_q = root_floor(one * one - 64'(h_q * h_q));
    if (i == 0 || i == last) model_phase = '0;
    else begin
      root_n = root_floor(n << 32);
      den = root_n * ((s_q == 0) ? 64'd1 : s_q);
      q = scaled_quotient(64'(STEP_Q32), PHASE_W + COORD_FRAC - 15, den);
      model_phase = model_phase + PHASE_W'((q + 1) >> 1);
    end
    u = 64'({model_phase, 8'h00});
    r = u & 64'h3FFF_FFFF;
    sq = longint'(quarter_sine(r));
    cq = longint'(quarter_sine(64'(ONE_Q30) - r));
    case (u[31:30])
      2'd0: begin cv = cq; sv = sq; end
      2'd1: begin cv = -sq; sv = cq; end
      2'd2: begin cv = -cq; sv = -sq; end
      default: begin cv = sq; sv = -cq; end
    endcase
    if (h_q > 32767) h_q = 32767;
    p.pos_x = to_coord(s_q, cv);
    p.pos_y = to_coord(s_q, sv);
    p.pos_z = h_q[15:0];
    p.point_index = i[15:0];
    p.last_point = (i == last);
    model_next = (i == last) ? '0 : COUNT_W'(i + 1);
    return p;
  endfunction

  // accept monitor and checker
  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && push && !full) begin
      expected_points.push_back(next_point(in_restart));
      items_in++;
      restarts_sent += in_restart;
    end
    if (rst_n && pop && !empty) begin
      points_out++;
      last_seen += out_last_point;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point item, index %0d", out_point_index);
      end else begin
        e = expected_points.pop_front();
        if (e.pos_x !== out_pos_x || e.pos_y !== out_pos_y || e.pos_z !== out_pos_z ||
            e.point_index !== out_point_index || e.last_point !== out_last_point) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch exp x=%0d y=%0d z=%0d i=%0d l=%0b got x=%0d y=%0d z=%0d i=%0d l=%0b",
                     $signed(e.pos_x), $signed(e.pos_y), $signed(e.pos_z), e.point_index,
                     e.last_point, out_pos_x, out_pos_y, out_pos_z, out_point_index,
                     out_last_point);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d points outstanding", expected_points.size());
      $display("spiral_sphere_point_generator_unit verification failed");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int w, n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        pop = 1'b0;
        repeat (w) @(negedge clk);
      end
      pop = 1'b1;
      n = points_out;
      while (points_out == n) @(negedge clk);
    end
  end

  task automatic send_point(input logic rs);
    int w, n;
    w = no_gaps ? 0 : $urandom_range(0, 17);
    if (w > 0) begin
      push = 1'b0;
      repeat (w) @(negedge clk);
    end
    push = 1'b1;
    in_restart = rs;
    n = items_in;
    while (items_in == n) @(negedge clk);
  endtask

  task automatic drain;
    push = 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic read_count_reg(input logic [COUNT_W-1:0] want);
    psel = 1'b1; pwrite = 1'b0; paddr = REG_POINT_COUNT; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[COUNT_W-1:0] !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("point_count read exp %0d got %0d", want, prdata);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic set_point_count(input logic [COUNT_W-1:0] v);
    drain();
    psel = 1'b1; pwrite = 1'b1; paddr = REG_POINT_COUNT; pwdata = CFG_DATA_W'(v);
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    model_count = v;
    read_count_reg(v);
  endtask

  task automatic test_reset_state;
    read_count_reg(POINT_COUNT_RESET);
    repeat (4) send_point(1'b0);
  endtask

  task automatic test_smallest_sets;
    set_point_count(16'd2);
    repeat (3) send_point(1'b0);
    set_point_count(16'd0);
    repeat (2) send_point(1'b0);
    set_point_count(16'd1);
    repeat (2) send_point(1'b0);
  endtask

  task automatic test_restart_and_shrink;
    set_point_count(16'd5);
    repeat (3) send_point(1'b0);
    send_point(1'b1);
    send_point(1'b0);
    send_point(1'b0);
    set_point_count(16'd2);
    repeat (2) send_point(1'b0);
  endtask

  task automatic test_largest_set;
    set_point_count(16'hFFFF);
    repeat (5) send_point(1'b0);
    send_point(1'b1);
  endtask

  task automatic test_random_sets;
    logic [COUNT_W-1:0] nc;
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: nc = 16'd2;
        5: nc = 16'hFFFF;
        8: nc = 16'd3;
        default: nc = COUNT_W'($urandom_range(2, 45));
      endcase
      if (ph == 3) nc = COUNT_W'($urandom_range(0, 65535));
      set_point_count(nc);
      no_gaps = (ph % 4 == 2);
      repeat (50) send_point($urandom_range(0, 11) == 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_smallest_sets();
    test_restart_and_shrink();
    test_largest_set();
    test_random_sets();
    drain();
    $display("sent %0d items (%0d restarts), checked %0d points, %0d set ends", items_in,
             restarts_sent, points_out, last_seen);
    $display("point counts from 0 to 65535 with random gaps and stalls, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_points.size() == 0)
      $display("spiral_sphere_point_generator_unit verification clean");
    else
      $display("spiral_sphere_point_generator_unit verification failed");
    $finish;
  end

endmodule
